@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL back end (fttlb_back.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/fttlb_pkg.sv @@
// Types and constants of the FIFO translation buffer.
package fttlb_pkg;

  localparam int TLB_ENTRIES_DEFAULT = 64;
  localparam int PID_W   = 8;
  localparam int PAGE_W  = 52;
  localparam int FRAME_W = 40;
  localparam int OP_W    = 2;
  localparam int CAP_W   = 7;
  localparam int RCNT_W  = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_LOOKUP,
    KIND_INSERT,
    KIND_FLUSH
  } kind_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [PID_W-1:0]   owner_id;
    logic [PAGE_W-1:0]  vpn;
    logic [FRAME_W-1:0] frame_in;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic               evicted;
    logic [RCNT_W-1:0]  removed_count;
  } out_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

@@ rtl/fifo_tlb_with_process_flush_unit.sv @@
// Fully associative translation buffer with FIFO replacement and per-process flush.
// A lookup or insert is served by a scan of the age-ordered entry ring at one RAM read
// per cycle; a flush walks the whole ring the same way. The back end handles one word
// at a time, while the front queue holds up to two more accepted words.
// Reset (rst, synchronous, active high) empties the buffer and the queue and sets
// capacity to 64; entry storage is not cleared, so no clearing pass is needed.
module fifo_tlb_with_process_flush_unit #(
  parameter int TLB_ENTRIES = fttlb_pkg::TLB_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fttlb_pkg::in_word_t         in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fttlb_pkg::out_word_t        out_data,
  input  logic                        cfg_we,
  input  logic [fttlb_pkg::CAP_W-1:0] cfg_wdata
);

  logic            q_valid;
  logic            q_pop;
  fttlb_pkg::cmd_t q_cmd;

  fttlb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  fttlb_back #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/fttlb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fttlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fttlb_front.sv @@
// Front end: accepts input words, decodes them and queues commands.
module fttlb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fttlb_pkg::in_word_t in_data,
  output logic                q_valid,
  output fttlb_pkg::cmd_t     q_cmd,
  input  logic                q_pop
);

  fttlb_pkg::cmd_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  fttlb_pkg::cmd_t dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec.pid   = in_data.owner_id;
    dec.page  = in_data.vpn;
    dec.frame = in_data.frame_in;
    unique case (in_data.operation)
      fttlb_pkg::OP_LOOKUP: dec.kind = fttlb_pkg::KIND_LOOKUP;
      fttlb_pkg::OP_INSERT: dec.kind = fttlb_pkg::KIND_INSERT;
      fttlb_pkg::OP_FLUSH:  dec.kind = fttlb_pkg::KIND_FLUSH;
      default:              dec.kind = fttlb_pkg::KIND_NOP;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/fttlb_back.sv @@
// Back end: walks the age-ordered entry ring to serve lookups, inserts and flushes.
`include "assert_macros.svh"

module fttlb_back #(
  parameter int TLB_ENTRIES = fttlb_pkg::TLB_ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fttlb_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                        q_valid,
  input  fttlb_pkg::cmd_t             q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fttlb_pkg::out_word_t        out_data
);

  localparam int IW   = $clog2(TLB_ENTRIES);
  localparam int CW   = $clog2(TLB_ENTRIES + 1);
  localparam int CMPW = (CW > fttlb_pkg::CAP_W) ? CW : fttlb_pkg::CAP_W;
  localparam int EW   = $bits(fttlb_pkg::entry_t);
  localparam int RW   = fttlb_pkg::RCNT_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  state_t                    state;
  logic [IW-1:0]             head;
  logic [CW-1:0]             count;
  logic [fttlb_pkg::CAP_W-1:0] cap;
  fttlb_pkg::cmd_t           cmd;
  logic [CW-1:0]             rd_issue;
  logic                      pend;
  logic [IW-1:0]             pend_addr;
  logic [CW-1:0]             keep_cnt;
  logic [CW-1:0]             rm_cnt;

  logic [CMPW-1:0]           cap_w;
  logic [CMPW-1:0]           eff_cap;
  logic                      full;
  logic                      issue;
  logic                      scan_end;
  logic [IW-1:0]             rd_addr;
  fttlb_pkg::entry_t         rd_entry;
  logic                      pid_match;
  logic                      key_match;
  logic                      start;
  logic                      we;
  logic [IW-1:0]             waddr;
  fttlb_pkg::entry_t         wdata;
  logic                      res_set;
  fttlb_pkg::out_word_t      res_data;

  // Ring position arithmetic: each operand is at most TLB_ENTRIES.
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base, input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(TLB_ENTRIES)) begin
      sum = sum - (IW+1)'(TLB_ENTRIES);
    end
    return sum[IW-1:0];
  endfunction

  always_comb begin
    cap_w = CMPW'(cap);
    if (cap_w == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_w > CMPW'(TLB_ENTRIES)) begin
      eff_cap = CMPW'(TLB_ENTRIES);
    end else begin
      eff_cap = cap_w;
    end
  end

  assign full      = (CMPW'(count) >= eff_cap);
  assign issue     = (rd_issue < count);
  assign scan_end  = !pend && !issue;
  assign rd_addr   = wrap(head, rd_issue[IW-1:0]);
  assign pid_match = pend && (rd_entry.pid == cmd.pid);
  assign key_match = pid_match && (rd_entry.page == cmd.page);
  assign start     = (state == S_IDLE) && q_valid && (!out_valid || out_ready);
  assign q_pop     = start;

  always_comb begin
    we    = 1'b0;
    waddr = wrap(head, count[IW-1:0]);
    wdata = '{pid: cmd.pid, page: cmd.page, frame: cmd.frame};
    unique case (state)
      S_SCAN: begin
        if (cmd.kind == fttlb_pkg::KIND_INSERT) begin
          if (key_match) begin
            we    = 1'b1;
            waddr = pend_addr;
          end else if (scan_end) begin
            // New key goes behind the youngest entry; after an eviction the
            // head moves up by one, which lands on the same position.
            we = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (pend && !pid_match) begin
          we    = 1'b1;
          waddr = wrap(head, keep_cnt[IW-1:0]);
          wdata = rd_entry;
        end
      end
      default: ;
    endcase
  end

  // Result word of the operation that finishes in this cycle.
  always_comb begin
    res_set  = 1'b0;
    res_data = '0;
    unique case (state)
      S_IDLE: res_set = start && (q_cmd.kind == fttlb_pkg::KIND_NOP);
      S_SCAN: begin
        if (key_match) begin
          res_set            = 1'b1;
          res_data.hit       = (cmd.kind == fttlb_pkg::KIND_LOOKUP);
          res_data.frame_out = (cmd.kind == fttlb_pkg::KIND_LOOKUP) ? rd_entry.frame : '0;
        end else if (scan_end) begin
          res_set          = 1'b1;
          res_data.evicted = (cmd.kind == fttlb_pkg::KIND_INSERT) && full;
        end
      end
      S_FLUSH: begin
        if (scan_end) begin
          res_set                = 1'b1;
          res_data.removed_count = RW'(rm_cnt);
        end
      end
      default: ;
    endcase
  end

  fttlb_ram #(
    .WIDTH (EW),
    .DEPTH (TLB_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      cap       <= fttlb_pkg::CAP_RESET;
      out_valid <= 1'b0;
      rd_issue  <= '0;
      pend      <= 1'b0;
      keep_cnt  <= '0;
      rm_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (res_set) begin
        out_valid <= 1'b1;
        out_data  <= res_data;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd      <= q_cmd;
            rd_issue <= '0;
            pend     <= 1'b0;
            keep_cnt <= '0;
            rm_cnt   <= '0;
            unique case (q_cmd.kind)
              fttlb_pkg::KIND_LOOKUP,
              fttlb_pkg::KIND_INSERT: state <= S_SCAN;
              fttlb_pkg::KIND_FLUSH:  state <= S_FLUSH;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) rd_issue <= rd_issue + CW'(1);
          pend      <= issue;
          pend_addr <= rd_addr;
          if (key_match) begin
            state <= S_IDLE;
          end else if (scan_end) begin
            if (cmd.kind == fttlb_pkg::KIND_INSERT) begin
              if (full) begin
                head <= wrap(head, IW'(1));
              end else begin
                count <= count + CW'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (issue) rd_issue <= rd_issue + CW'(1);
          pend <= issue;
          if (pend) begin
            if (pid_match) rm_cnt <= rm_cnt + CW'(1);
            else           keep_cnt <= keep_cnt + CW'(1);
          end
          if (scan_end) begin
            count <= keep_cnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(TLB_ENTRIES))
  `ASSERT_ALWAYS(a_head_bound, clk, rst, (IW+1)'(head) < (IW+1)'(TLB_ENTRIES))
  `ASSERT_IMPLIES(a_out_empty_busy, clk, rst, state != S_IDLE, !out_valid)
  `ASSERT_ALWAYS(a_keep_le_read, clk, rst, (keep_cnt + rm_cnt) <= rd_issue)

endmodule

@@ tb/sv/fifo_tlb_with_process_flush_unit_tb.sv @@
// Self-checking testbench for the FIFO translation buffer with per-process flush.
`timescale 1ns / 1ps

module fifo_tlb_with_process_flush_unit_tb;

  localparam int NUM_SLOTS = 64;
  localparam int OP_W    = fttlb_pkg::OP_W;
  localparam int PID_W   = fttlb_pkg::PID_W;
  localparam int PAGE_W  = fttlb_pkg::PAGE_W;
  localparam int FRAME_W = fttlb_pkg::FRAME_W;
  localparam int CAP_W   = fttlb_pkg::CAP_W;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fttlb_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fttlb_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  fifo_tlb_with_process_flush_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Translation buffer mirror.
  logic [CAP_W-1:0]   mirror_cap;
  logic               tlb_valid [NUM_SLOTS];
  logic [PID_W-1:0]   tlb_pid   [NUM_SLOTS];
  logic [PAGE_W-1:0]  tlb_page  [NUM_SLOTS];
  logic [FRAME_W-1:0] tlb_frame [NUM_SLOTS];
  int                 age_list  [$];

  fttlb_pkg::in_word_t  pending_words [$];
  fttlb_pkg::out_word_t expected_words [$];
  int send_idle_pct = 26;
  int recv_idle_pct = 45;
  int error_count = 0;
  int lookup_hits = 0;
  int evictions = 0;
  int flushes = 0;

  // Acceptance seen at the last rising edge.
  logic in_ready_seen = 1'b0;
  int accepted = 0;

  function automatic int find_slot(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
    for (int s = 0; s < NUM_SLOTS; s++)
      if (tlb_valid[s] && tlb_pid[s] == pid && tlb_page[s] == page) return s;
    return -1;
  endfunction

  function automatic fttlb_pkg::out_word_t translate_word(fttlb_pkg::in_word_t w);
    fttlb_pkg::out_word_t r;
    int s;
    int cap;
    int kept [$];
    r = '0;
    if (mirror_cap == '0) cap = 1;
    else if (int'(mirror_cap) > NUM_SLOTS) cap = NUM_SLOTS;
    else cap = int'(mirror_cap);
    case (w.operation)
      fttlb_pkg::OP_LOOKUP: begin
        s = find_slot(w.owner_id, w.vpn);
        if (s >= 0) begin
          r.hit = 1'b1;
          r.frame_out = tlb_frame[s];
        end
      end
      fttlb_pkg::OP_INSERT: begin
        s = find_slot(w.owner_id, w.vpn);
        if (s >= 0) begin
          tlb_frame[s] = w.frame_in;
        end else begin
          if (age_list.size() >= cap) begin
            tlb_valid[age_list.pop_front()] = 1'b0;
            r.evicted = 1'b1;
          end
          for (s = 0; s < NUM_SLOTS; s++)
            if (!tlb_valid[s]) break;
          if (s < NUM_SLOTS) begin
            tlb_valid[s] = 1'b1;
            tlb_pid[s] = w.owner_id;
            tlb_page[s] = w.vpn;
            tlb_frame[s] = w.frame_in;
            age_list = {age_list, s};
          end
        end
      end
      fttlb_pkg::OP_FLUSH: begin
        foreach (age_list[i]) begin
          if (tlb_pid[age_list[i]] == w.owner_id) begin
            tlb_valid[age_list[i]] = 1'b0;
            r.removed_count = r.removed_count + 1'b1;
          end else begin
            kept = {kept, age_list[i]};
          end
        end
        age_list = kept;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: payload changes only on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    fttlb_pkg::out_word_t e;
    if (rst) begin
      in_ready_seen <= 1'b0;
    end else begin
      in_ready_seen <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        e = translate_word(in_data);
        if (e.hit) lookup_hits++;
        if (e.evicted) evictions++;
        if (in_data.operation == fttlb_pkg::OP_FLUSH) flushes++;
        expected_words = {expected_words, e};
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          error_count++;
        end else begin
          e = expected_words.pop_front();
          if (out_data.hit !== e.hit) begin
            $error("hit: expected %0h, got %0h", e.hit, out_data.hit);
            error_count++;
          end
          if (out_data.frame_out !== e.frame_out) begin
            $error("frame_out: expected %0h, got %0h", e.frame_out, out_data.frame_out);
            error_count++;
          end
          if (out_data.evicted !== e.evicted) begin
            $error("evicted: expected %0h, got %0h", e.evicted, out_data.evicted);
            error_count++;
          end
          if (out_data.removed_count !== e.removed_count) begin
            $error("removed_count: expected %0h, got %0h", e.removed_count,
                   out_data.removed_count);
            error_count++;
          end
        end
      end
    end
  end

  function automatic fttlb_pkg::in_word_t make_word(logic [OP_W-1:0] op, int pid,
                                                    logic [PAGE_W-1:0] page,
                                                    logic [FRAME_W-1:0] frame);
    fttlb_pkg::in_word_t w;
    w.operation = op;
    w.owner_id = pid[PID_W-1:0];
    w.vpn = page;
    w.frame_in = frame;
    return w;
  endfunction

  function automatic void queue_word(fttlb_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Most random page keys come from a small pool so lookups and re-inserts hit often.
  logic [PAGE_W-1:0] page_pool [16];

  function automatic fttlb_pkg::in_word_t random_word();
    int r;
    int pid;
    logic [OP_W-1:0] op;
    logic [PAGE_W-1:0] page;
    r = $urandom_range(99);
    if (r < 40) op = fttlb_pkg::OP_LOOKUP;
    else if (r < 88) op = fttlb_pkg::OP_INSERT;
    else if (r < 96) op = fttlb_pkg::OP_FLUSH;
    else op = OP_UNUSED;
    page = ($urandom_range(9) == 0) ? PAGE_W'(rand64()) : page_pool[$urandom_range(15)];
    pid = ($urandom_range(7) == 0) ? int'($urandom_range(255)) : int'($urandom_range(3));
    return make_word(op, pid, page, FRAME_W'(rand64()));
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (NUM_SLOTS + 10) @(posedge clk);
  endtask

  task automatic write_capacity(int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[CAP_W-1:0];
    mirror_cap = value[CAP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    repeat (count) queue_word(random_word());
    while (pending_words.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [PAGE_W-1:0] all_ones_page;
    logic [FRAME_W-1:0] all_ones_frame;
    all_ones_page = '1;
    all_ones_frame = '1;
    mirror_cap = fttlb_pkg::CAP_RESET;
    foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
    foreach (page_pool[i]) page_pool[i] = PAGE_W'(rand64());
    page_pool[0] = '0;
    page_pool[1] = all_ones_page;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, duplicate insert, unused code.
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 0, '0, '0));
    queue_word(make_word(fttlb_pkg::OP_INSERT, 0, '0, all_ones_frame));
    queue_word(make_word(fttlb_pkg::OP_INSERT, 255, all_ones_page, '0));
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 0, '0, '0));
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 255, all_ones_page, all_ones_frame));
    queue_word(make_word(fttlb_pkg::OP_INSERT, 0, '0, 40'h5_5555_5555));
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 0, '0, '0));
    queue_word(make_word(OP_UNUSED, 255, all_ones_page, all_ones_frame));
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 1, '0, '0));
    queue_word(make_word(fttlb_pkg::OP_FLUSH, 7, '0, '0));
    queue_word(make_word(fttlb_pkg::OP_FLUSH, 255, all_ones_page, all_ones_frame));
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 255, all_ones_page, '0));
    wait_drained();

    // Fill all 64 slots for one process, then evict and flush them all.
    for (int i = 0; i < 66; i++)
      queue_word(make_word(fttlb_pkg::OP_INSERT, 9, PAGE_W'(i), FRAME_W'(i)));
    queue_word(make_word(fttlb_pkg::OP_LOOKUP, 9, '0, '0));
    queue_word(make_word(fttlb_pkg::OP_FLUSH, 9, '0, '0));
    wait_drained();

    // Capacity 1, then 0, which behaves as 1.
    write_capacity(1);
    send_idle_pct = 26;
    recv_idle_pct = 45;
    run_random(300);
    wait_drained();
    write_capacity(0);
    run_random(100);
    wait_drained();

    // Lowering capacity below the fill level.
    write_capacity(127);
    send_idle_pct = 45;
    recv_idle_pct = 26;
    run_random(400);
    wait_drained();
    write_capacity(5);
    run_random(300);
    wait_drained();

    write_capacity(64);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);
    wait_drained();
    write_capacity(17);
    run_random(300);
    wait_drained();

    $display("Covered %0d words: %0d lookup hits, %0d evictions, %0d flushes.",
             accepted, lookup_hits, evictions, flushes);
    $display("Capacity settings 0, 1, 5, 17, 64 and 127 were exercised, with and without stalls.");
    if (error_count == 0)
      $display("fifo_tlb_with_process_flush_unit verification clean");
    else
      $display("fifo_tlb_with_process_flush_unit verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("fifo_tlb_with_process_flush_unit verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fttlb_pkg.sv
rtl/fttlb_ram.sv
rtl/fttlb_front.sv
rtl/fttlb_back.sv
rtl/fifo_tlb_with_process_flush_unit.sv
tb/sv/fifo_tlb_with_process_flush_unit_tb.sv
